### hw/rtl/load_cell_tare_and_average_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef LOAD_CELL_TARE_AND_AVERAGE_DEFINES_SVH
`define LOAD_CELL_TARE_AND_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCTA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load cell block: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load cell block: next-cycle check failed");

`endif

### hw/rtl/lcta_pkg.sv
package lcta_pkg;

    localparam int CHANNELS    = 5;
    localparam int SAMPLE_BITS = 24;
    localparam int RAW_W       = 24;
    localparam int SUM_W       = 32;
    localparam int VAL_W       = 32;
    localparam int GAIN_W      = 32;
    localparam int CNT_W       = 8;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_IDX_W   = $clog2(CHANNELS + 1);
    localparam int CFG_DATA_W  = 32;
    localparam int DIFF_W      = VAL_W + 1;
    localparam int PROD_W      = DIFF_W + GAIN_W;

    // Divider retires this many quotient bits per cycle.
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_ITER      = SUM_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_ITER);

    localparam logic [CFG_IDX_W-1:0]  CFG_AVERAGE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  CFG_GAIN_FIRST    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0]  CFG_GAIN_LAST     = CFG_IDX_W'(CHANNELS);
    localparam logic [CNT_W-1:0]      COUNT_RESET       = CNT_W'(1);
    localparam logic [GAIN_W-1:0]     GAIN_RESET        = GAIN_W'(65536);

    localparam logic OP_WEIGH = 1'b0;
    localparam logic OP_TARE  = 1'b1;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic signed [SUM_W-1:0] sext_sample(input logic [RAW_W-1:0] raw);
        return SUM_W'($signed(raw[SAMPLE_BITS-1:0]));
    endfunction

endpackage

### hw/rtl/lcta_ram.sv
module lcta_ram #(
    parameter int AW = 3,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    localparam int DEPTH = 1 << AW;

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rdata;

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/lcta_div.sv
module lcta_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcta_pkg::t_div_req i_req,
    output lcta_pkg::t_div_rsp o_rsp
);
    import lcta_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_div;
    logic [CNT_W-1:0]     r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [SUM_W-1:0]     r_q;
    logic [CNT_W-1:0]     n_rem;
    logic [SUM_W-1:0]     n_quo;
    logic [CNT_W:0]       c_trial;
    logic [SUM_W-1:0]     c_mag;

    assign c_mag = i_req.dividend[SUM_W-1] ? (~i_req.dividend + SUM_W'(1)) : i_req.dividend;

    // Restoring division on the magnitude, a few quotient bits per cycle.
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        c_trial = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            c_trial = {n_rem, n_quo[SUM_W-1]};
            n_quo   = {n_quo[SUM_W-2:0], 1'b0};
            if (c_trial >= {1'b0, r_div}) begin
                c_trial  = c_trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = c_trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_ITER - 1);
                r_rem  <= '0;
                r_quo  <= c_mag;
                r_div  <= i_req.divisor;
                r_neg  <= i_req.dividend[SUM_W-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= r_neg ? (~n_quo + SUM_W'(1)) : n_quo;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

### hw/rtl/load_cell_tare_and_average.sv
// Load-cell tare and averaging for five bridge converters. Each request is one frame: five
// raw 24-bit two's-complement words plus an op bit (1 tare, 0 weigh). The words are
// sign-extended and added to the tare or weigh sums, which live in a small synchronous
// memory indexed by {op, channel}; the block reads, adds and writes back one channel at
// a time. When the run's frame counter reaches average_count (0 acts as 1), each sum
// goes through one shared signed divider (truncation toward zero, two quotient bits per
// cycle) and the sums are cleared. A tare run stores the averages in the offset memory
// and reports them with run_kind 1. A weigh run reports (average - offset) * gain, gain
// signed Q16.16, saturated to signed Q16.16, with run_kind 0. A frame that ends no run
// returns to idle after writing its last channel; a completing run also waits on the
// divider for each channel and then for the output register to free up. One frame is
// in work at a time, while the last result waits in its own output register. Both
// memories read as zero until written, so no clearing pass follows reset.
// Configuration: index 0 average_count, indexes 1..5 gain_ch0..gain_ch4; write only while
// the block is idle.
`include "load_cell_tare_and_average_defines.svh"

module load_cell_tare_and_average (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lcta_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lcta_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic [lcta_pkg::RAW_W-1:0]          i_raw_ch0,
    input  logic [lcta_pkg::RAW_W-1:0]          i_raw_ch1,
    input  logic [lcta_pkg::RAW_W-1:0]          i_raw_ch2,
    input  logic [lcta_pkg::RAW_W-1:0]          i_raw_ch3,
    input  logic [lcta_pkg::RAW_W-1:0]          i_raw_ch4,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_run_kind,
    output logic signed [lcta_pkg::VAL_W-1:0]   o_value_ch0,
    output logic signed [lcta_pkg::VAL_W-1:0]   o_value_ch1,
    output logic signed [lcta_pkg::VAL_W-1:0]   o_value_ch2,
    output logic signed [lcta_pkg::VAL_W-1:0]   o_value_ch3,
    output logic signed [lcta_pkg::VAL_W-1:0]   o_value_ch4
);
    import lcta_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_ACC  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_OFF  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_SAT  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [CNT_W-1:0]         r_avg_count;
    logic signed [GAIN_W-1:0] r_gain [CHANNELS];

    // Run bookkeeping.
    logic [CNT_W-1:0] r_tare_frames;
    logic [CNT_W-1:0] r_weigh_frames;

    // Request in work.
    logic              r_op;
    logic              r_done;
    logic [CNT_W-1:0]  r_count;
    logic [CH_W-1:0]   r_ch;
    logic [RAW_W-1:0]  r_raw [CHANNELS];

    // Result path.
    logic signed [VAL_W-1:0]  r_avg;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0]  r_res [CHANNELS];

    // Output register.
    logic                     r_out_valid;
    logic                     r_out_kind;
    logic signed [VAL_W-1:0]  r_out [CHANNELS];

    logic [RAW_W-1:0]  raw_in [CHANNELS];
    logic              in_acc;
    logic              last_ch;
    logic [CNT_W-1:0]  count_eff;
    logic [CNT_W-1:0]  frames_new;
    logic              run_done;
    logic [SUM_W-1:0]  sum_rdata;
    logic [SUM_W-1:0]  sum_new;
    logic              sum_we;
    logic [VAL_W-1:0]  off_rdata;
    logic              off_we;
    logic              out_load;
    logic [PROD_W-1:VAL_W-1] prod_top;
    logic              prod_fits;
    logic signed [VAL_W-1:0] prod_sat;

    t_div_req div_req;
    t_div_rsp div_rsp;

    assign raw_in[0] = i_raw_ch0;
    assign raw_in[1] = i_raw_ch1;
    assign raw_in[2] = i_raw_ch2;
    assign raw_in[3] = i_raw_ch3;
    assign raw_in[4] = i_raw_ch4;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign last_ch    = (r_ch == CH_W'(CHANNELS - 1));

    // A run ends once its counter reaches the current count, zero counting as one.
    assign count_eff  = (r_avg_count == '0) ? CNT_W'(1) : r_avg_count;
    assign frames_new = (i_op == OP_TARE) ? (r_tare_frames + CNT_W'(1))
                                          : (r_weigh_frames + CNT_W'(1));
    assign run_done   = (frames_new >= count_eff);

    // Sum memory: read in S_RD, add and write back in S_ACC. Channels of one request are
    // distinct entries and the next request reads after the last write, so no forwarding.
    assign sum_new = sum_rdata + sext_sample(r_raw[r_ch]);
    assign sum_we  = (r_state == S_ACC);

    lcta_ram #(
        .AW (CH_W + 1),
        .DW (SUM_W)
    ) u_sums (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (sum_we),
        .i_waddr ({r_op, r_ch}),
        .i_wdata (r_done ? '0 : sum_new),
        .i_raddr ({r_op, r_ch}),
        .o_rdata (sum_rdata)
    );

    // Offset memory: a tare run writes it as each quotient lands; a weigh run reads it
    // only from a later request, after every write has settled.
    assign off_we = (r_state == S_DIV) && div_rsp.done && (r_op == OP_TARE);

    lcta_ram #(
        .AW (CH_W),
        .DW (VAL_W)
    ) u_offsets (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (off_we),
        .i_waddr (r_ch),
        .i_wdata (div_rsp.quotient),
        .i_raddr (r_ch),
        .o_rdata (off_rdata)
    );

    assign div_req.start    = (r_state == S_ACC) && r_done;
    assign div_req.dividend = sum_new;
    assign div_req.divisor  = r_count;

    lcta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Clamp the product to the signed Q16.16 range.
    assign prod_top  = r_prod[PROD_W-1:VAL_W-1];
    assign prod_fits = (&prod_top) || !(|prod_top);
    assign prod_sat  = prod_fits ? r_prod[VAL_W-1:0]
                     : (r_prod[PROD_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                         : {1'b0, {(VAL_W-1){1'b1}}});

    assign out_load = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_done)       n_state = S_DIV;
                else if (last_ch) n_state = S_IDLE;
                else              n_state = S_RD;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_op == OP_WEIGH) n_state = S_OFF;
                    else if (last_ch)     n_state = S_EMIT;
                    else                  n_state = S_RD;
                end
            end
            S_OFF: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_SAT;
            end
            S_SAT: begin
                n_state = last_ch ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_avg_count    <= COUNT_RESET;
            r_tare_frames  <= '0;
            r_weigh_frames <= '0;
            r_out_valid    <= 1'b0;
            r_ch           <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_gain[i] <= GAIN_RESET;
            end
        end else begin
            r_state <= n_state;

            // Configuration writes; indexes past the gains drop.
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_AVERAGE_COUNT) begin
                    r_avg_count <= i_cfg_data[CNT_W-1:0];
                end else if (i_cfg_index <= CFG_GAIN_LAST) begin
                    r_gain[CH_W'(i_cfg_index - CFG_GAIN_FIRST)] <= i_cfg_data[GAIN_W-1:0];
                end
            end

            // Latch the request and advance its run counter.
            if (in_acc) begin
                r_op    <= i_op;
                r_done  <= run_done;
                r_count <= count_eff;
                r_ch    <= '0;
                for (int i = 0; i < CHANNELS; i++) begin
                    r_raw[i] <= raw_in[i];
                end
                if (i_op == OP_TARE) begin
                    r_tare_frames <= run_done ? '0 : frames_new;
                end else begin
                    r_weigh_frames <= run_done ? '0 : frames_new;
                end
            end

            if ((r_state == S_ACC) && !r_done && !last_ch) begin
                r_ch <= r_ch + CH_W'(1);
            end

            if ((r_state == S_DIV) && div_rsp.done) begin
                r_avg <= div_rsp.quotient;
                if (r_op == OP_TARE) begin
                    r_res[r_ch] <= div_rsp.quotient;
                    if (!last_ch) r_ch <= r_ch + CH_W'(1);
                end
            end

            if (r_state == S_OFF) begin
                r_diff <= DIFF_W'(r_avg) - DIFF_W'($signed(off_rdata));
            end

            if (r_state == S_MUL) begin
                r_prod <= r_diff * r_gain[r_ch];
            end

            if (r_state == S_SAT) begin
                r_res[r_ch] <= prod_sat;
                if (!last_ch) r_ch <= r_ch + CH_W'(1);
            end

            // Load the next result, or drop the shown one when it is taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= r_op;
                for (int i = 0; i < CHANNELS; i++) begin
                    r_out[i] <= r_res[i];
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_run_kind  = r_out_kind;
    assign o_value_ch0 = r_out[0];
    assign o_value_ch1 = r_out[1];
    assign o_value_ch2 = r_out[2];
    assign o_value_ch3 = r_out[3];
    assign o_value_ch4 = r_out[4];

    `LCTA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_acc, !o_in_ready)
    `LCTA_ASSERT_IMPL(a_quotient_in_wait, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV)
    `LCTA_ASSERT_NEXT(a_emit_shows_result, i_clk, i_rst_n, out_load, o_out_valid && o_in_ready)

endmodule
